// ===== hw/rtl/xs64s_pkg.sv =====
`default_nettype none

package xs64s_pkg;

    // Generator constants.
    localparam logic [63:0] GOLDEN_SEED  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SCRAMBLE_MUL = 64'h2545_F491_4F6C_DD1D;

    // Field widths.
    localparam int WORD_W  = 64;
    localparam int FRAC_W  = 53;
    localparam int BOUND_W = 32;
    localparam int SPAN_W  = 33;
    localparam int OP_W    = 2;
    localparam int STEP_W  = 6;

    // Byte-padded result beat: raw word, fraction, ranged value.
    localparam int OUT_DATA_W = 152;
    localparam int OUT_PAD_W  = OUT_DATA_W - WORD_W - FRAC_W - BOUND_W;

    // Operation codes carried in the request tuser.
    localparam logic [OP_W-1:0] OP_RAW   = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAC  = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;

    // One xorshift step with the shifts 12, 25 and 27.
    function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = x ^ (x >> 12);
        b = a ^ (a << 25);
        return b ^ (b >> 27);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xorshift64_star_generator_core.sv =====
`default_nettype none

// xorshift64* random number generator. One request beat (operation in tuser,
// bounds in tdata) gives one result beat. The state advances by one xorshift
// step, then the new state is multiplied by the scramble constant with a
// bit-serial shift-and-add unit, one multiplier bit per cycle. Range requests
// then take the remainder by the 33-bit span with a restoring divider, one
// dividend bit per cycle. An empty range request (high not above low) skips
// the step, the multiply and the divide and returns low as its value. One
// request is worked on at a time; a finished result sits in the output
// register, so the next request is taken while that beat waits. Writing the
// seed reloads the state (zero selects the golden-ratio constant) and must
// only be done while no request is in progress.
module xorshift64_star_generator_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Seed register write port.
    input  wire logic         i_cfg_wr_en,
    input  wire logic [63:0]  i_cfg_wr_data,
    // Request stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // [31:0] range_low, [63:32] range_high
    input  wire logic [1:0]   s_axis_tuser,   // [1:0] operation
    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [151:0]      m_axis_tdata    // [63:0] raw_word, [116:64] fraction,
                                              // [148:117] ranged_value, [151:149] zero
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_fsm;

    t_fsm r_fsm, n_fsm;

    logic [xs64s_pkg::WORD_W-1:0]  r_gen, n_gen;
    logic [xs64s_pkg::WORD_W-1:0]  r_mcand, n_mcand;
    logic [xs64s_pkg::WORD_W-1:0]  r_acc, n_acc;
    logic [xs64s_pkg::BOUND_W-1:0] r_rem, n_rem;
    logic [xs64s_pkg::SPAN_W-1:0]  r_span, n_span;
    logic [xs64s_pkg::BOUND_W-1:0] r_lo, n_lo;
    logic [xs64s_pkg::OP_W-1:0]    r_op, n_op;
    logic [xs64s_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic [xs64s_pkg::WORD_W-1:0]  r_out_raw, n_out_raw;
    logic [xs64s_pkg::FRAC_W-1:0]  r_out_frac, n_out_frac;
    logic [xs64s_pkg::BOUND_W-1:0] r_out_rng, n_out_rng;

    logic                          in_beat;
    logic                          out_free;
    logic [xs64s_pkg::BOUND_W-1:0] in_lo;
    logic [xs64s_pkg::BOUND_W-1:0] in_hi;
    logic [xs64s_pkg::SPAN_W-1:0]  in_span;
    logic                          in_empty;
    logic [xs64s_pkg::WORD_W-1:0]  gen_next;
    logic [xs64s_pkg::WORD_W-1:0]  acc_sum;
    logic [xs64s_pkg::SPAN_W-1:0]  div_trial;
    logic [xs64s_pkg::SPAN_W-1:0]  div_diff;
    logic                          last_step;

    // Handshake and request decode.
    assign s_axis_tready = (r_fsm == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_lo         = s_axis_tdata[31:0];
    assign in_hi         = s_axis_tdata[63:32];
    assign in_span       = {in_hi[31], in_hi} - {in_lo[31], in_lo} + 33'd1;
    assign in_empty      = (s_axis_tuser == xs64s_pkg::OP_RANGE) &&
                           ($signed(in_hi) <= $signed(in_lo));
    assign gen_next      = xs64s_pkg::xorshift_step(r_gen);
    assign last_step     = (r_cnt == '1);

    // Shift-and-add datapath: one multiplier bit per cycle.
    assign acc_sum = xs64s_pkg::SCRAMBLE_MUL[r_cnt] ? (r_acc + r_mcand) : r_acc;

    // Restoring remainder datapath: one dividend bit per cycle.
    assign div_trial = {r_rem, r_acc[xs64s_pkg::WORD_W-1]};
    assign div_diff  = div_trial - r_span;

    // Sequencer and datapath next state.
    always_comb begin
        n_fsm       = r_fsm;
        n_gen       = r_gen;
        n_mcand     = r_mcand;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_span      = r_span;
        n_lo        = r_lo;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_raw   = r_out_raw;
        n_out_frac  = r_out_frac;
        n_out_rng   = r_out_rng;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_fsm)
            ST_IDLE: begin
                if (i_cfg_wr_en) begin
                    n_gen = (i_cfg_wr_data == '0) ? xs64s_pkg::GOLDEN_SEED : i_cfg_wr_data;
                end
                if (in_beat) begin
                    n_op   = s_axis_tuser;
                    n_lo   = in_lo;
                    n_span = in_span;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_acc  = '0;
                    if (in_empty) begin
                        n_fsm = ST_DONE;
                    end else begin
                        n_gen   = gen_next;
                        n_mcand = gen_next;
                        n_fsm   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_acc   = acc_sum;
                n_mcand = r_mcand << 1;
                n_cnt   = r_cnt + 1'b1;
                if (last_step) begin
                    n_fsm = (r_op == xs64s_pkg::OP_RANGE) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                n_acc = r_acc << 1;
                n_cnt = r_cnt + 1'b1;
                if (div_trial >= r_span) begin
                    n_rem = div_diff[xs64s_pkg::BOUND_W-1:0];
                end else begin
                    n_rem = div_trial[xs64s_pkg::BOUND_W-1:0];
                end
                if (last_step) begin
                    n_fsm = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_raw   = '0;
                    n_out_frac  = '0;
                    n_out_rng   = '0;
                    case (r_op)
                        xs64s_pkg::OP_FRAC: begin
                            n_out_frac = r_acc[xs64s_pkg::WORD_W-1:xs64s_pkg::WORD_W-xs64s_pkg::FRAC_W];
                        end
                        xs64s_pkg::OP_RANGE: begin
                            n_out_rng = r_lo + r_rem;
                        end
                        default: begin
                            n_out_raw = r_acc;
                        end
                    endcase
                    n_fsm = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_gen       <= xs64s_pkg::GOLDEN_SEED;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_gen       <= n_gen;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mcand    <= n_mcand;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_span     <= n_span;
        r_lo       <= n_lo;
        r_op       <= n_op;
        r_out_raw  <= n_out_raw;
        r_out_frac <= n_out_frac;
        r_out_rng  <= n_out_rng;
    end

    // Result beat.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{xs64s_pkg::OUT_PAD_W{1'b0}}, r_out_rng, r_out_frac, r_out_raw};

    // The generator state never falls into the all-zero lockup.
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generator state is zero");

    // The partial remainder stays below the span while dividing.
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_DIV) |-> ({1'b0, r_rem} < r_span))
        else $error("remainder not below span");

    // An accepted request always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_fsm != ST_IDLE))
        else $error("request accepted without starting work");

    // A result beat is only loaded from the done state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_fsm == ST_DONE))
        else $error("result loaded outside done state");

endmodule

`default_nettype wire
